// File: rtl/csrdp_pkg.sv
// Shared types and constants of the CSR sparse row dot product block.
`timescale 1ns / 1ps

package csrdp_pkg;

    localparam int IDX_W   = 12;
    localparam int VAL_W   = 32;
    localparam int SUM_W   = 64;
    localparam int Q_DEPTH = 4;

    typedef enum logic [1:0] {
        REQ_LOAD  = 2'd0,
        REQ_ELEM  = 2'd1,
        REQ_EMPTY = 2'd2
    } t_req_type;

    typedef struct packed {
        logic                    empty_row;
        logic                    last;
        logic signed [VAL_W-1:0] value;
        logic signed [VAL_W-1:0] vec;
    } t_work;

endpackage

// File: rtl/csrdp_if.sv
// Valid/ready channel interfaces for request and result items.
`timescale 1ns / 1ps

interface csrdp_in_if;
    logic                  valid;
    logic                  ready;
    logic [1:0]            req_type;
    logic [11:0]           index;
    logic signed [31:0]    value;
    logic                  last;

    modport source (output valid, req_type, index, value, last, input ready);
    modport sink   (input valid, req_type, index, value, last, output ready);
endinterface

interface csrdp_out_if;
    logic                  valid;
    logic                  ready;
    logic signed [63:0]    row_sum;
    logic                  saturated;

    modport source (output valid, row_sum, saturated, input ready);
    modport sink   (input valid, row_sum, saturated, output ready);
endinterface

// File: rtl/csrdp_front.sv
// Front end: accepts request items, keeps the vector store, forwards work items.
`timescale 1ns / 1ps

module csrdp_front #(
    parameter int VECTOR_DEPTH = 4096
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    csrdp_in_if.sink        i_req,
    input  logic            i_full,
    output logic            o_push,
    output csrdp_pkg::t_work o_work
);
    import csrdp_pkg::*;

    localparam int AW = (VECTOR_DEPTH > 1) ? $clog2(VECTOR_DEPTH) : 1;

    logic [VAL_W-1:0]    r_mem [VECTOR_DEPTH];
    logic [VAL_W-1:0]    r_rd;
    logic                r_s1_vld;
    logic                n_s1_vld;
    logic                r_empty;
    logic                r_last;
    logic                r_inrng;
    logic signed [VAL_W-1:0] r_value;
    logic                w_acc;
    logic                w_inrng;
    logic                w_load;
    logic                w_elem;
    logic [AW+IDX_W-1:0] w_wide;
    logic [AW-1:0]       w_addr;

    assign w_acc   = i_req.valid && i_req.ready;
    assign w_inrng = ({20'd0, i_req.index} < 32'(VECTOR_DEPTH));
    assign w_wide  = {{AW{1'b0}}, i_req.index};
    assign w_addr  = w_wide[AW-1:0];
    assign o_push  = r_s1_vld && !i_full;
    assign i_req.ready = !r_s1_vld || !i_full;

    always_comb begin
        w_load = 1'b0;
        w_elem = 1'b0;
        unique case (t_req_type'(i_req.req_type))
            REQ_LOAD: begin
                w_load = 1'b1;
            end
            REQ_ELEM: begin
                w_elem = 1'b1;
            end
            default: begin
            end
        endcase
    end

    always_comb begin
        n_s1_vld = r_s1_vld;
        if (w_acc) begin
            n_s1_vld = w_elem || (i_req.req_type == REQ_EMPTY);
        end else if (o_push) begin
            n_s1_vld = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_acc && w_load && w_inrng) begin
            r_mem[w_addr] <= i_req.value;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_acc && w_elem) begin
            r_rd <= r_mem[w_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld <= 1'b0;
        end else begin
            r_s1_vld <= n_s1_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_acc) begin
            r_empty <= !w_elem;
            r_last  <= i_req.last;
            r_inrng <= w_inrng;
            r_value <= i_req.value;
        end
    end

    always_comb begin
        o_work.empty_row = r_empty;
        o_work.last      = r_last;
        o_work.value     = r_value;
        o_work.vec       = r_inrng ? r_rd : '0;
    end

endmodule

// File: rtl/csrdp_queue.sv
// Short work queue between front end and back end.
`timescale 1ns / 1ps

module csrdp_queue (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  csrdp_pkg::t_work i_work,
    input  logic             i_pop,
    output csrdp_pkg::t_work o_work,
    output logic             o_full,
    output logic             o_empty
);
    import csrdp_pkg::*;

    localparam int PW = $clog2(Q_DEPTH);
    localparam int CW = $clog2(Q_DEPTH + 1);
    localparam logic [CW-1:0] DEPTH_C = CW'(Q_DEPTH);

    t_work          r_buf [Q_DEPTH];
    logic [PW-1:0]  r_wr;
    logic [PW-1:0]  r_rd;
    logic [CW-1:0]  r_count;
    logic           w_push;
    logic           w_pop;

    assign o_full  = (r_count == DEPTH_C);
    assign o_empty = (r_count == '0);
    assign w_push  = i_push && !o_full;
    assign w_pop   = i_pop && !o_empty;
    assign o_work  = r_buf[r_rd];

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_buf[r_wr] <= i_work;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            if (w_push) begin
                r_wr <= r_wr + 1'b1;
            end
            if (w_pop) begin
                r_rd <= r_rd + 1'b1;
            end
            if (w_push && !w_pop) begin
                r_count <= r_count + 1'b1;
            end else if (w_pop && !w_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

`ifndef SYNTHESIS
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= DEPTH_C) else $error("queue count beyond depth");
    a_no_push_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_full |-> !i_push) else $error("push into full queue");
    a_no_pop_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_empty |-> !i_pop) else $error("pop from empty queue");
    a_push_grows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_push && !w_pop) |=> r_count == $past(r_count) + 1'b1)
        else $error("queue count did not advance");
`endif

endmodule

// File: rtl/csrdp_back.sv
// Back end: multiply, truncate, saturating accumulate and result register.
`timescale 1ns / 1ps

module csrdp_back #(
    parameter int FRAC_BITS = 16
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_empty,
    input  csrdp_pkg::t_work i_work,
    output logic             o_pop,
    csrdp_out_if.source      o_res
);
    import csrdp_pkg::*;

    localparam logic signed [SUM_W-1:0] SUM_MAX = {1'b0, {(SUM_W-1){1'b1}}};
    localparam logic signed [SUM_W-1:0] SUM_MIN = {1'b1, {(SUM_W-1){1'b0}}};

    logic                    w_en;
    logic                    r_a_vld;
    logic                    r_a_last;
    logic                    r_a_empty;
    logic signed [SUM_W-1:0] r_a_prod;
    logic signed [SUM_W-1:0] r_acc;
    logic                    r_clip;
    logic                    r_out_vld;
    logic signed [SUM_W-1:0] r_out_sum;
    logic                    r_out_sat;
    logic signed [SUM_W-1:0] w_sh;
    logic signed [SUM_W-1:0] w_sum;
    logic signed [SUM_W-1:0] w_sat;
    logic                    w_ovf;

    assign w_en  = !r_out_vld || o_res.ready;
    assign o_pop = w_en && !i_empty;

    assign w_sh  = r_a_prod >>> FRAC_BITS;
    assign w_sum = r_acc + w_sh;
    assign w_ovf = (r_acc[SUM_W-1] == w_sh[SUM_W-1]) && (w_sum[SUM_W-1] != r_acc[SUM_W-1]);
    assign w_sat = w_ovf ? (r_acc[SUM_W-1] ? SUM_MIN : SUM_MAX) : w_sum;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_vld <= 1'b0;
        end else if (w_en) begin
            r_a_vld <= !i_empty;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_a_last  <= i_work.last;
            r_a_empty <= i_work.empty_row;
            r_a_prod  <= SUM_W'(i_work.value * i_work.vec);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_acc     <= '0;
            r_clip    <= 1'b0;
            r_out_vld <= 1'b0;
        end else if (w_en) begin
            r_out_vld <= r_a_vld && (r_a_empty || r_a_last);
            if (r_a_vld && !r_a_empty) begin
                if (r_a_last) begin
                    r_acc  <= '0;
                    r_clip <= 1'b0;
                end else begin
                    r_acc  <= w_sat;
                    r_clip <= r_clip || w_ovf;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en && r_a_vld) begin
            if (r_a_empty) begin
                r_out_sum <= '0;
                r_out_sat <= 1'b0;
            end else if (r_a_last) begin
                r_out_sum <= w_sat;
                r_out_sat <= r_clip || w_ovf;
            end
        end
    end

    assign o_res.valid     = r_out_vld;
    assign o_res.row_sum   = r_out_sum;
    assign o_res.saturated = r_out_sat;

endmodule

// File: rtl/csr_sparse_row_dot_product_top.sv
// Top level of the CSR sparse row dot product block.
//
//  channel  | dir | payload                          | accepted when
//  i_req    | in  | req_type, index, value, last     | valid && ready
//  o_res    | out | row_sum, saturated               | valid && ready
//
//  One item per cycle sustained unless the work queue is full; an item passes
//  through store read, queue, multiply and accumulate on its way to a result.
//  The single accumulate register sets the rate: one add per element.
//  A four-entry queue lets the front keep taking items while results stall.
//  Synchronous active-low reset clears control, accumulator and clip flag;
//  the vector store is not cleared.
`timescale 1ns / 1ps

module csr_sparse_row_dot_product_top #(
    parameter int VECTOR_DEPTH = 4096,
    parameter int FRAC_BITS    = 16
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    csrdp_in_if.sink     i_req,
    csrdp_out_if.source  o_res
);
    import csrdp_pkg::*;

    logic  w_push;
    logic  w_pop;
    logic  w_full;
    logic  w_empty;
    t_work w_front_work;
    t_work w_back_work;

    csrdp_front #(
        .VECTOR_DEPTH(VECTOR_DEPTH)
    ) u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (i_req),
        .i_full  (w_full),
        .o_push  (w_push),
        .o_work  (w_front_work)
    );

    csrdp_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_work  (w_front_work),
        .i_pop   (w_pop),
        .o_work  (w_back_work),
        .o_full  (w_full),
        .o_empty (w_empty)
    );

    csrdp_back #(
        .FRAC_BITS(FRAC_BITS)
    ) u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_empty (w_empty),
        .i_work  (w_back_work),
        .o_pop   (w_pop),
        .o_res   (o_res)
    );

endmodule
